[design/binary_contour_hollow_3x3_defines.svh]
// Assertion macros shared by the contour hollowing design files.
`ifndef BINARY_CONTOUR_HOLLOW_3X3_DEFINES_SVH
`define BINARY_CONTOUR_HOLLOW_3X3_DEFINES_SVH
`ifndef SYNTH
`define BCH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("binary_contour_hollow_3x3: check failed");
`define BCH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("binary_contour_hollow_3x3: check failed");
`else
`define BCH_ASSERT(lbl, prop)
`define BCH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/bch_pkg.sv]
// Shared constants and types of the binary contour hollowing block.
package bch_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 3 * PIX_W;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  localparam int OUT_FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    MODE_PUSH  = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_e;

  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             frame_end;
  } out_item_t;

endpackage

[design/binary_contour_hollow_3x3.sv]
// Timing: a result enters the output queue at the edge that accepts its transaction and
// is then offered from the queue; pixels of a row come out during the next row's pushes.
// Throughput: one transaction per cycle; a row-end push can yield two results, absorbed by
// a four-entry output queue, so input ready drops only while the output is backed up.
// Reset: 640 x 480 frame, positions and window cleared; line memories keep their contents.
`include "binary_contour_hollow_3x3_defines.svh"
module binary_contour_hollow_3x3 #(
  parameter int MAX_WIDTH  = bch_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bch_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bch_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bch_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [bch_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bch_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                            last_of_run_o,
  output logic                            frame_end_o
);
  import bch_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Decision for the middle pixel of a 3x3 window; columns pack upper, middle, lower from the low byte up.
  function automatic logic [PIX_W-1:0] decide(logic [COL_W-1:0] lft, logic [COL_W-1:0] mid,
                                              logic [COL_W-1:0] rgt, logic hl, logic hr,
                                              logic hu, logic hd);
    logic [COL_W-1:0] vmask;
    logic [COL_W-1:0] smask;
    logic [PIX_W-1:0] res;
    vmask = {(hd ? 8'hFF : 8'h00), 8'h00, (hu ? 8'hFF : 8'h00)};
    smask = vmask | 24'h00FF00;
    priority if (mid[15:8] != '0) begin
      res = mid[15:8];
    end else if ((mid & vmask) != '0) begin
      res = '0;
    end else if (hl && ((lft & smask) != '0)) begin
      res = '0;
    end else if (hr && ((rgt & smask) != '0)) begin
      res = '0;
    end else begin
      res = 8'hFF;
    end
    return res;
  endfunction

  logic [CFG_W_W-1:0] cfg_w_q, cfg_w_d;
  logic [CFG_H_W-1:0] cfg_h_q, cfg_h_d;
  logic [CW-1:0]      col_q, col_d;
  logic [HW-1:0]      row_q, row_d;
  logic [PW-1:0]      drain_q, drain_d;
  logic [15:0]        first_col_q, first_col_d;
  logic               byp_q, byp_d;
  logic [PIX_W-1:0]   byp_up_q, byp_mid_q;

  logic [PW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic               in_acc, push_go, drain_go, draining;
  logic [PIX_W-1:0]   ram_up, ram_mid, rd_up, rd_mid;
  logic [CW-1:0]      rd_addr;
  logic [COL_W-1:0]   new_col, cell1_in, win_left, win_mid;
  logic [PW-1:0]      c_plus1;
  logic               row_end, frame_rows_done, c_ge1, c_ge2, r_ge1, r_ge2;
  logic               drain_last, d_ge1;
  logic [15:0]        first_col;
  logic [PIX_W-1:0]   res_a, res_b, res_d;
  logic               emit_a, emit_b;
  cell_ctrl_t         ctrl_left, ctrl_mid;
  out_item_t          item0, item1;
  out_item_t          out_item;
  logic               push0, push1;

  // Effective frame size after clamping the registers.
  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = PW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = PW'(MAX_WIDTH);
    end else begin
      eff_w = PW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          cfg_w_d = cfg_data_i[CFG_W_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_h_d = cfg_data_i[CFG_H_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign draining = (drain_q != '0);
  assign push_go  = in_acc && (mode_i == MODE_PUSH) && !draining;
  assign drain_go = in_acc && (mode_i == MODE_DRAIN) && draining;

  // A write in the previous cycle to the address read in that cycle is forwarded.
  assign rd_up  = byp_q ? byp_up_q : ram_up;
  assign rd_mid = byp_q ? byp_mid_q : ram_mid;

  assign new_col = {((mode_i == MODE_PUSH) ? pixel_in_i : 8'h00), rd_mid, rd_up};

  assign c_plus1         = PW'(col_q) + PW'(1);
  assign row_end         = (c_plus1 >= eff_w);
  assign frame_rows_done = (({1'b0, row_q} + (HW + 1)'(1)) >= {1'b0, eff_h});
  assign c_ge1           = (col_q != '0);
  assign c_ge2           = (col_q > CW'(1));
  assign r_ge1           = (row_q != '0);
  assign r_ge2           = (row_q > HW'(1));
  assign drain_last      = (drain_q >= eff_w);
  assign d_ge1           = (drain_q > PW'(1));

  assign first_col = c_ge1 ? first_col_q : {pixel_in_i, rd_mid};

  assign res_a = decide(win_left, win_mid, new_col, c_ge2, 1'b1, r_ge2, 1'b1);
  assign res_b = decide(win_mid, new_col, '0, c_ge1, 1'b0, r_ge2, 1'b1);
  assign res_d = decide(win_left, win_mid, new_col, d_ge1, !drain_last, r_ge1, 1'b0);

  assign emit_a = push_go && r_ge1 && c_ge1;
  assign emit_b = push_go && r_ge1 && row_end;

  always_comb begin
    push0 = drain_go || emit_a || emit_b;
    push1 = emit_a && emit_b;
    item1 = '{pixel: res_b, last: 1'b1, frame_end: 1'b0};
    priority if (drain_go) begin
      item0 = '{pixel: res_d, last: 1'b1, frame_end: drain_last};
    end else if (emit_a) begin
      item0 = '{pixel: res_a, last: !emit_b, frame_end: 1'b0};
    end else begin
      item0 = item1;
    end
  end

  // Position update and window cell control.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    drain_d     = drain_q;
    first_col_d = first_col_q;
    ctrl_left   = '{en: 1'b0, clr: 1'b0};
    ctrl_mid    = '{en: 1'b0, clr: 1'b0};
    cell1_in    = new_col;
    if (push_go) begin
      if (!c_ge1) begin
        first_col_d = {pixel_in_i, rd_mid};
      end
      if (row_end) begin
        col_d     = '0;
        ctrl_left = '{en: 1'b0, clr: 1'b1};
        if (frame_rows_done) begin
          // The last row is drained from the line memories; seed column zero now.
          drain_d  = PW'(1);
          cell1_in = {8'h00, first_col};
          ctrl_mid = '{en: 1'b1, clr: 1'b0};
        end else begin
          row_d    = row_q + HW'(1);
          ctrl_mid = '{en: 1'b0, clr: 1'b1};
        end
      end else begin
        col_d     = CW'(c_plus1);
        ctrl_left = '{en: 1'b1, clr: 1'b0};
        ctrl_mid  = '{en: 1'b1, clr: 1'b0};
      end
    end else if (drain_go) begin
      if (drain_last) begin
        drain_d   = '0;
        row_d     = '0;
        col_d     = '0;
        ctrl_left = '{en: 1'b0, clr: 1'b1};
        ctrl_mid  = '{en: 1'b0, clr: 1'b1};
      end else begin
        drain_d   = drain_q + PW'(1);
        ctrl_left = '{en: 1'b1, clr: 1'b0};
        ctrl_mid  = '{en: 1'b1, clr: 1'b0};
      end
    end
  end

  // The memories are read ahead, from the next position, for the column the next transaction needs.
  assign rd_addr = (drain_d != '0) ? CW'(drain_d) : col_d;
  assign byp_d   = push_go && (col_q == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= IMAGE_WIDTH_RST;
      cfg_h_q <= IMAGE_HEIGHT_RST;
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      cfg_w_q <= cfg_w_d;
      cfg_h_q <= cfg_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_col_q <= first_col_d;
    byp_up_q    <= rd_mid;
    byp_mid_q   <= pixel_in_i;
  end

  bch_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (push_go),
    .waddr_i (col_q),
    .wdata_i (rd_mid),
    .raddr_i (rd_addr),
    .rdata_o (ram_up)
  );

  bch_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (push_go),
    .waddr_i (col_q),
    .wdata_i (pixel_in_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_mid)
  );

  bch_col_cell u_cell_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_mid),
    .col_i  (cell1_in),
    .col_o  (win_mid)
  );

  bch_col_cell u_cell_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_left),
    .col_i  (win_mid),
    .col_o  (win_left)
  );

  bch_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .item0_i     (item0),
    .push1_i     (push1),
    .item1_i     (item1),
    .space2_o    (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  assign pixel_out_o   = out_item.pixel;
  assign last_of_run_o = out_item.last;
  assign frame_end_o   = out_item.frame_end;

  `BCH_ASSERT(a_drain_col_zero, (drain_q != '0) |-> (col_q == '0))
  `BCH_ASSERT(a_byp_from_push, byp_q |-> $past(push_go))
  `BCH_ASSERT(a_drain_exit, (drain_go && drain_last) |=> ((drain_q == '0) && (row_q == '0)))

endmodule

[design/bch_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
module bch_ram #(
  parameter int WIDTH = bch_pkg::PIX_W,
  parameter int DEPTH = bch_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bch_col_cell.sv]
// One window cell: holds a three-pixel column, takes the incoming column when enabled and clears on request.
module bch_col_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bch_pkg::cell_ctrl_t        ctrl_i,
  input  logic [bch_pkg::COL_W-1:0]  col_i,
  output logic [bch_pkg::COL_W-1:0]  col_o
);
  import bch_pkg::*;

  logic [COL_W-1:0] col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (ctrl_i.clr) begin
      col_d = '0;
    end else if (ctrl_i.en) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

[design/bch_out_fifo.sv]
// Result queue that takes up to two items per cycle and hands out one.
`include "binary_contour_hollow_3x3_defines.svh"
module bch_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push0_i,
  input  bch_pkg::out_item_t item0_i,
  input  logic               push1_i,
  input  bch_pkg::out_item_t item1_i,
  output logic               space2_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bch_pkg::out_item_t out_item_o
);
  import bch_pkg::*;

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  out_item_t        mem_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, wptr_nx, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rptr_q];
  assign space2_o    = (count_q <= CNT_W'(OUT_FIFO_DEPTH - 2));
  assign wptr_nx     = wptr_q + PTR_W'(1);

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (push0_i) begin
      wptr_d = push1_i ? (wptr_q + PTR_W'(2)) : wptr_nx;
    end
    if (pop) begin
      rptr_d = rptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(push0_i) + CNT_W'(push1_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wptr_q] <= item0_i;
    end
    if (push1_i) begin
      mem_q[wptr_nx] <= item1_i;
    end
  end

  `BCH_ASSERT(a_no_overflow, push0_i |-> (count_q <= CNT_W'(OUT_FIFO_DEPTH - 2)))
  `BCH_ASSERT(a_pair_in_order, push1_i |-> push0_i)
  `BCH_ASSERT(a_pop_drops, (pop && !push0_i) |=> (count_q == $past(count_q) - CNT_W'(1)))
  `BCH_ASSERT(a_count_bound, count_q <= CNT_W'(OUT_FIFO_DEPTH))

endmodule
